// ===== rtl/chc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the chained hash counter.
// No dependencies; imported by every module of the block.
package chc_pkg;

  localparam int HASH_W    = 32;
  localparam int KEY_W     = 64;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 7;
  localparam int KEY_WORDS_MAX = 8;
  localparam int DIV_BITS  = 4;   // remainder bits retired per cycle

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_FIND = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HASH_W-1:0] key_hash;
    logic [KEY_W-1:0]  key_word0;
    logic [KEY_W-1:0]  key_word1;
    logic [KEY_W-1:0]  key_word2;
    logic [KEY_W-1:0]  key_word3;
    logic [KEY_W-1:0]  key_word4;
    logic [KEY_W-1:0]  key_word5;
    logic [KEY_W-1:0]  key_word6;
    logic [KEY_W-1:0]  key_word7;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } resp_t;

  typedef struct packed {
    logic load_req;
    logic div_step;
    logic bkt_rd;
    logic walk_chk;
    logic walk_adv;
    logic walk_hit;
    logic add_hit;
    logic ins_rd;
    logic ins_w1;
    logic ins_w2;
    logic del_w1;
    logic del_w2;
    logic set_res;
    logic out_load;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic walk_end;
    logic key_match;
    logic op_add;
    logic op_del;
    logic hit;
    logic full;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/chc_ctl.sv =====
`timescale 1ns / 1ps
// Sequencer of the chained hash counter: clear pass, modulo, chain walk, update.
// Depends on chc_pkg; drives the datapath chc_dp through cmd_t, reads sts_t.
module chc_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output chc_pkg::cmd_t cmd,
  input  chc_pkg::sts_t sts
);
  import chc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_BKT, S_WALK, S_CMP, S_OPER,
    S_INS1, S_INS2, S_DEL2, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_BKT;
        else cmd.div_step = 1'b1;
      end
      S_BKT: begin
        cmd.bkt_rd = 1'b1;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        cmd.walk_chk = 1'b1;
        state_nxt    = sts.walk_end ? S_OPER : S_CMP;
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.walk_hit = 1'b1;
          state_nxt    = S_OPER;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WALK;
        end
      end
      S_OPER: begin
        cmd.set_res = 1'b1;
        priority if (sts.op_add && sts.hit) begin
          cmd.add_hit = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.op_add && !sts.full) begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS1;
        end else if (sts.op_del && sts.hit) begin
          cmd.del_w1 = 1'b1;
          state_nxt  = S_DEL2;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_INS1: begin
        cmd.ins_w1 = 1'b1;
        state_nxt  = S_INS2;
      end
      S_INS2: begin
        cmd.ins_w2 = 1'b1;
        state_nxt  = S_RESP;
      end
      S_DEL2: begin
        cmd.del_w2 = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/chc_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the chained hash counter: modulo unit, bucket and slot memories,
// chain walk registers and the output register. Depends on chc_pkg.
module chc_dp #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 16,
  parameter int KEY_WORDS        = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chc_pkg::req_t              in_data,
  input  logic                       cfg_we,
  input  logic [chc_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output chc_pkg::resp_t             out_data,
  input  chc_pkg::cmd_t              cmd,
  output chc_pkg::sts_t              sts
);
  import chc_pkg::*;

  localparam int SW    = $clog2(SLOTS_PER_BUCKET + 2);
  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int AW    = BW + SW;
  localparam int DW    = $clog2(MAX_BUCKETS + 1);
  localparam int RW    = DW + 1;
  localparam int EW    = HASH_W + KEY_WORDS * KEY_W;
  localparam int STEPS = HASH_W / DIV_BITS;
  localparam int STW   = $clog2(STEPS + 1);

  typedef struct packed {
    logic [SW-1:0] tail;
    logic [SW-1:0] free;
    logic [SW-1:0] used;
  } bkt_ent_t;

  // configuration
  logic [CFG_W-1:0] bcnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      bcnt_r <= cfg_wdata;
    end
  end

  // request and modulo unit
  req_t           req_r;
  logic [DW-1:0]  div_r, div_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [HASH_W-1:0] hsh_r, hsh_nxt;
  logic [STW-1:0] step_r;
  logic [EW-1:0]  ent_in;
  logic [KEY_W-1:0] kw [KEY_WORDS_MAX];

  always_comb begin
    if (bcnt_r == '0) begin
      div_nxt = DW'(1);
    end else if (int'(bcnt_r) > MAX_BUCKETS) begin
      div_nxt = DW'(MAX_BUCKETS);
    end else begin
      div_nxt = DW'(bcnt_r);
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    hsh_nxt = hsh_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_nxt = {rem_nxt[RW-2:0], hsh_nxt[HASH_W-1]};
      hsh_nxt = {hsh_nxt[HASH_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, div_r}) rem_nxt = rem_nxt - {1'b0, div_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
      div_r <= div_nxt;
      rem_r <= '0;
      hsh_r <= in_data.key_hash;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      hsh_r <= hsh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load_req) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + STW'(1);
    end
  end

  always_comb begin
    kw[0] = req_r.key_word0;
    kw[1] = req_r.key_word1;
    kw[2] = req_r.key_word2;
    kw[3] = req_r.key_word3;
    kw[4] = req_r.key_word4;
    kw[5] = req_r.key_word5;
    kw[6] = req_r.key_word6;
    kw[7] = req_r.key_word7;
    ent_in = '0;
    for (int w = 0; w < KEY_WORDS; w++) ent_in[w*KEY_W +: KEY_W] = kw[w];
    ent_in[EW-1 -: HASH_W] = req_r.key_hash;
  end

  logic [BW-1:0] bkt;
  assign bkt = rem_r[BW-1:0];

  // memories and walk registers
  bkt_ent_t      bkt_mem [2**BW];
  logic [SW-1:0] nxt_mem [2**AW];
  logic [EW-1:0] ent_mem [2**AW];
  logic [CNT_W-1:0] cnt_mem [2**AW];

  bkt_ent_t      bkt_q, bkt_wd;
  logic [BW-1:0] bkt_wa;
  logic          bkt_we;
  logic [SW-1:0] nxt_q, nxt_wd;
  logic [AW-1:0] nxt_wa, nxt_ra;
  logic          nxt_we, nxt_re;
  logic [EW-1:0] ent_q;
  logic [CNT_W-1:0] cnt_q, cnt_wd, cnt_sat;
  logic [AW-1:0] cnt_wa;
  logic          cnt_we;

  logic [SW-1:0] p_r, cur_r, n_r, hit_r, prev_r;
  logic          hitv_r;
  logic [AW-1:0] clr_r;
  logic [SW-1:0] clr_slot;

  assign clr_slot = clr_r[SW-1:0];
  assign cnt_sat  = (&cnt_q) ? cnt_q : cnt_q + CNT_W'(1);

  always_comb begin
    nxt_we = 1'b1;
    nxt_wa = {bkt, prev_r};
    nxt_wd = nxt_q;
    priority if (cmd.clr_step) begin
      nxt_wa = clr_r;
      nxt_wd = (clr_slot == '0) ? '0 : clr_slot + SW'(1);
    end else if (cmd.ins_w1) begin
      nxt_wa = {bkt, bkt_q.free};
      nxt_wd = '0;
    end else if (cmd.ins_w2) begin
      nxt_wa = {bkt, bkt_q.tail};
      nxt_wd = bkt_q.free;
    end else if (cmd.del_w1) begin
      nxt_wa = {bkt, prev_r};
      nxt_wd = nxt_q;
    end else if (cmd.del_w2) begin
      nxt_wa = {bkt, hit_r};
      nxt_wd = bkt_q.free;
    end else begin
      nxt_we = 1'b0;
    end
  end

  always_comb begin
    nxt_re = 1'b1;
    priority if (cmd.bkt_rd) begin
      nxt_ra = {bkt, SW'(0)};
    end else if (cmd.walk_chk) begin
      nxt_ra = {bkt, nxt_q};
    end else if (cmd.ins_rd) begin
      nxt_ra = {bkt, bkt_q.free};
    end else begin
      nxt_ra = {bkt, nxt_q};
      nxt_re = 1'b0;
    end
  end

  always_comb begin
    bkt_we = 1'b1;
    bkt_wa = bkt;
    bkt_wd = bkt_q;
    priority if (cmd.clr_step) begin
      bkt_we = (clr_slot == '0);
      bkt_wa = clr_r[AW-1:SW];
      bkt_wd = '{tail: '0, free: SW'(1), used: '0};
    end else if (cmd.ins_w1) begin
      bkt_wd = '{tail: bkt_q.free, free: nxt_q, used: bkt_q.used + SW'(1)};
    end else if (cmd.del_w1) begin
      bkt_wd = '{tail: (bkt_q.tail == hit_r) ? prev_r : bkt_q.tail,
                 free: hit_r, used: bkt_q.used - SW'(1)};
    end else begin
      bkt_we = 1'b0;
    end
  end

  assign cnt_we = cmd.ins_w1 || cmd.add_hit;
  assign cnt_wa = cmd.ins_w1 ? {bkt, bkt_q.free} : {bkt, hit_r};
  assign cnt_wd = cmd.ins_w1 ? CNT_W'(1) : cnt_sat;

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_q <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (cmd.bkt_rd) bkt_q <= bkt_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_w1) ent_mem[{bkt, bkt_q.free}] <= ent_in;
    if (cmd.walk_chk) ent_q <= ent_mem[{bkt, nxt_q}];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd.walk_chk) cnt_q <= cnt_mem[{bkt, nxt_q}];
  end

  always_ff @(posedge clk) begin
    if (cmd.bkt_rd) begin
      p_r <= '0;
      n_r <= '0;
    end else if (cmd.walk_adv) begin
      p_r <= cur_r;
      n_r <= n_r + SW'(1);
    end
    if (cmd.walk_chk) cur_r <= nxt_q;
    if (cmd.walk_hit) begin
      hit_r  <= cur_r;
      prev_r <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hitv_r <= 1'b0;
      clr_r  <= '0;
    end else begin
      if (cmd.bkt_rd) hitv_r <= 1'b0;
      else if (cmd.walk_hit) hitv_r <= 1'b1;
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
    end
  end

  // result and output register
  resp_t res_r, res_nxt;
  logic  out_valid_r;
  resp_t out_r;

  always_comb begin
    res_nxt = '{status: ST_OK, count: '0};
    priority if (sts.op_add) begin
      priority if (hitv_r) res_nxt.count = cnt_sat;
      else if (sts.full) res_nxt.status = ST_FULL;
      else res_nxt.count = CNT_W'(1);
    end else if (sts.op_del) begin
      if (!hitv_r) res_nxt.status = ST_MISS;
    end else begin
      if (hitv_r) res_nxt.count = cnt_q;
      else res_nxt.status = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) res_r <= res_nxt;
    if (cmd.out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the sequencer
  assign sts.clr_done  = &clr_r;
  assign sts.div_done  = (step_r == STW'(STEPS));
  assign sts.walk_end  = (n_r >= bkt_q.used) || (nxt_q == '0) ||
                         (int'(nxt_q) > SLOTS_PER_BUCKET);
  assign sts.key_match = (ent_q == ent_in);
  assign sts.op_add    = (req_r.req_type == REQ_ADD);
  assign sts.op_del    = (req_r.req_type == REQ_DEL);
  assign sts.hit       = hitv_r;
  assign sts.full      = (int'(bkt_q.used) >= SLOTS_PER_BUCKET) || (bkt_q.free == '0) ||
                         (int'(bkt_q.free) > SLOTS_PER_BUCKET);
  assign sts.out_free  = !out_valid_r || !out_stall;

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bkt_rd |-> rem_r < {1'b0, div_r})
    else $error("bucket index not below divisor");

  a_hit_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_hit |=> hitv_r && hit_r != '0)
    else $error("hit latched on sentinel slot");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_w1 |-> int'(bkt_q.used) < SLOTS_PER_BUCKET)
    else $error("insert into full bucket");

endmodule

// ===== rtl/chained_hash_counter_unit.sv =====
`timescale 1ns / 1ps
// Flow: a modulo of the hash by the bucket count, then the chain walk with one slot read and
//   key compare per entry, then the update, if any. One word in flight; the next is taken once
//   the result is in the output reg.
// Reset: synchronous; a clearing pass over every slot address rebuilds the free lists, with
//   in_stall high; config writes are taken.
module chained_hash_counter_unit #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 16,
  parameter int KEY_WORDS        = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  chc_pkg::req_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output chc_pkg::resp_t            out_data,
  input  logic                      cfg_we,
  input  logic [chc_pkg::CFG_W-1:0] cfg_wdata
);
  import chc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, then per word: modulo, walk, update, drop result
  chc_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: holds the request, the tables and the result word
  chc_dp #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .KEY_WORDS        (KEY_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== dv/chained_hash_counter_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for chained_hash_counter_unit: a local table model predicts
// status and count per word. Depends on chc_pkg and the RTL of the block.
module chained_hash_counter_unit_test;
  import chc_pkg::*;

  localparam int NB = 64;
  localparam int NS = 16;
  localparam int ROW = NS + 1;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  resp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  chained_hash_counter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state: per bucket, an ordered list of entries; slot ids do not affect
  // results, so order and contents are all that matter.
  typedef struct {
    logic [HASH_W-1:0] h;
    logic [KEY_W-1:0] k[8];
    logic [CNT_W-1:0] c;
  } entry_t;
  entry_t chain_q[NB][$];
  logic [CFG_W-1:0] divisor_reg = BUCKET_COUNT_RST;

  req_t pending_q[$];
  resp_t expected_q[$];
  int errors = 0;
  bit feeding = 1'b0;

  function automatic bit key_eq(entry_t e, req_t r);
    return e.h == r.key_hash && e.k[0] == r.key_word0 && e.k[1] == r.key_word1 &&
      e.k[2] == r.key_word2 && e.k[3] == r.key_word3 && e.k[4] == r.key_word4 &&
      e.k[5] == r.key_word5 && e.k[6] == r.key_word6 && e.k[7] == r.key_word7;
  endfunction

  function automatic resp_t count_table(req_t r);
    resp_t o;
    int d, b, hit;
    entry_t e;
    o.status = ST_OK;
    o.count = '0;
    d = int'(divisor_reg);
    if (d == 0) d = 1;
    if (d > NB) d = NB;
    b = int'(r.key_hash % HASH_W'(d));
    hit = -1;
    foreach (chain_q[b][i]) if (hit < 0 && key_eq(chain_q[b][i], r)) hit = i;
    if (r.req_type == REQ_ADD) begin
      if (hit >= 0) begin
        if (chain_q[b][hit].c != '1) chain_q[b][hit].c++;
        o.count = chain_q[b][hit].c;
      end else if (chain_q[b].size() >= NS) begin
        o.status = ST_FULL;
      end else begin
        e.h = r.key_hash;
        e.k[0] = r.key_word0; e.k[1] = r.key_word1; e.k[2] = r.key_word2;
        e.k[3] = r.key_word3; e.k[4] = r.key_word4; e.k[5] = r.key_word5;
        e.k[6] = r.key_word6; e.k[7] = r.key_word7;
        e.c = CNT_W'(1);
        chain_q[b].push_back(e);
        o.count = CNT_W'(1);
      end
    end else if (r.req_type == REQ_DEL) begin
      if (hit >= 0) chain_q[b].delete(hit);
      else o.status = ST_MISS;
    end else begin
      // type 3 acts as find
      if (hit >= 0) o.count = chain_q[b][hit].c;
      else o.status = ST_MISS;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, resp_t got, resp_t want);
    $display("mismatch %s: got st=%0d cnt=%0h want st=%0d cnt=%0h",
             what, got.status, got.count, want.status, want.count);
    errors++;
  endtask

  // Driver: bursts of words with random gaps; hold payload while stalled.
  // An accepted word is popped first, so the next one is always at the front.
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      void'(pending_q.pop_front());
    end
    if (in_valid && in_stall) begin
      // hold
    end else if (!rst_n || !feeding || pending_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else begin
      in_data <= pending_q[0];
      in_valid <= 1'b1;
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
      end
    end
  end

  // Predict on acceptance, so the model sees words in DUT order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_q.push_back(count_table(in_data));
  end

  // Monitor and receiver stall pattern.
  int stall_mode = 0;
  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", out_data, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status) report_mismatch("status", out_data, want);
        else if (out_data.count !== want.count) report_mismatch("count", out_data, want);
      end
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic req_t make_req(logic [1:0] op, logic [HASH_W-1:0] h, logic [KEY_W-1:0] k);
    req_t r;
    r.req_type = op;
    r.key_hash = h;
    r.key_word0 = k; r.key_word1 = ~k; r.key_word2 = k ^ 64'h5a5a;
    r.key_word3 = '0; r.key_word4 = k; r.key_word5 = '0; r.key_word6 = '0; r.key_word7 = k;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain();
    feeding = 1'b1;
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    feeding = 1'b0;
  endtask

  task automatic set_divisor(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    divisor_reg = v;
  endtask

  task automatic random_phase(int n, int keys);
    req_t r;
    int pick;
    logic [HASH_W-1:0] hpool[16];
    logic [KEY_W-1:0] kpool[16];
    for (int i = 0; i < 16; i++) begin
      hpool[i] = $urandom();
      kpool[i] = rand64();
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, keys - 1);
      r = make_req(2'($urandom_range(0, 3)), hpool[pick], kpool[pick]);
      if ($urandom_range(0, 1) == 0) r.req_type = REQ_ADD;
      if ($urandom_range(0, 9) == 0) begin
        // noise: full random key, and a near-miss variant
        r.key_hash = $urandom();
        r.key_word0 = rand64(); r.key_word1 = rand64(); r.key_word2 = rand64();
        r.key_word3 = rand64(); r.key_word4 = rand64(); r.key_word5 = rand64();
        r.key_word6 = rand64(); r.key_word7 = rand64();
      end else if ($urandom_range(0, 15) == 0) begin
        r.key_word6 = rand64();
      end
      pending_q.push_back(r);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every op, miss/delete/head and tail delete.
    pending_q.push_back(make_req(REQ_FIND, 32'd0, 64'd0));
    pending_q.push_back(make_req(REQ_DEL, 32'd0, 64'd0));
    pending_q.push_back(make_req(REQ_ADD, 32'hffffffff, '1));
    pending_q.push_back(make_req(REQ_ADD, 32'hffffffff, '1));
    pending_q.push_back(make_req(REQ_SPARE, 32'hffffffff, '1));
    pending_q.push_back(make_req(REQ_ADD, 32'd0, 64'd0));
    pending_q.push_back(make_req(REQ_ADD, 32'd64, 64'd1));
    pending_q.push_back(make_req(REQ_DEL, 32'd64, 64'd1));   // tail delete
    pending_q.push_back(make_req(REQ_ADD, 32'd128, 64'd2));  // append after it
    pending_q.push_back(make_req(REQ_FIND, 32'd128, 64'd2));
    pending_q.push_back(make_req(REQ_DEL, 32'd0, 64'd0));    // head delete
    pending_q.push_back(make_req(REQ_FIND, 32'd1, 64'd0));   // same key, other hash
    drain();

    // One bucket: fill it past full.
    set_divisor(7'd1);
    for (int i = 0; i < 18; i++) pending_q.push_back(make_req(REQ_ADD, i * 7, 64'h100 + i));
    pending_q.push_back(make_req(REQ_DEL, 32'd35, 64'h105));
    pending_q.push_back(make_req(REQ_ADD, 32'd999, 64'h999));
    drain();
    random_phase(100, 16);

    set_divisor(7'd0);
    random_phase(60, 12);
    set_divisor(7'd127);
    random_phase(80, 16);
    set_divisor(7'd3);
    random_phase(120, 16);
    set_divisor(7'd64);
    random_phase(140, 10);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/chc_pkg.sv
rtl/chc_ctl.sv
rtl/chc_dp.sv
rtl/chained_hash_counter_unit.sv
dv/chained_hash_counter_unit_test.sv
